/* src/compass_heading_from_xy_macros.svh */
// assertion macros for the compass heading block
`ifndef COMPASS_HEADING_FROM_XY_MACROS_SVH
`define COMPASS_HEADING_FROM_XY_MACROS_SVH

// checked on every clock edge outside reset
`define CHXY_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define CHXY_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/chxy_pkg.sv */
// shared constants and the arctangent table of the compass heading block
`default_nettype none

package chxy_pkg;

	localparam int IN_W      = 16;
	localparam int OUT_W     = 16;
	localparam int ANG_FRAC  = 20;
	localparam int PRESCALE  = 14;
	localparam int TABLE_LEN = 24;
	localparam int XW        = 33;
	localparam int ZW        = 32;
	localparam int TW        = 30;
	localparam int ATAN_W    = 27;

	localparam logic [TW-1:0] A90  = TW'(90) << ANG_FRAC;
	localparam logic [TW-1:0] A180 = TW'(180) << ANG_FRAC;
	localparam logic [TW-1:0] A360 = TW'(360) << ANG_FRAC;

	typedef enum logic [1:0] {
		QUAD_PP = 2'b00,
		QUAD_PN = 2'b01,
		QUAD_NP = 2'b10,
		QUAD_NN = 2'b11
	} quad_t;

	// atan(2^-i) in degrees, 20 fraction bits
	localparam logic [ATAN_W-1:0] ATAN_TAB [0:TABLE_LEN-1] = '{
		27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121,
		27'd3750058,  27'd1876857,  27'd938658,   27'd469357,
		27'd234682,   27'd117342,   27'd58671,    27'd29335,
		27'd14668,    27'd7334,     27'd3667,     27'd1833,
		27'd917,      27'd458,      27'd229,      27'd115,
		27'd57,       27'd29,       27'd14,       27'd7
	};

endpackage

`default_nettype wire

/* src/chxy_if.sv */
// handshake channels: field pair in, heading out
`default_nettype none

interface chxy_xy_if import chxy_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [IN_W-1:0] field_x;
	logic signed [IN_W-1:0] field_y;

	modport source (output valid, output field_x, output field_y, input ready);
	modport sink   (input valid, input field_x, input field_y, output ready);
endinterface

interface chxy_hdg_if import chxy_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] heading_deg;

	modport source (output valid, output heading_deg, input ready);
	modport sink   (input valid, input heading_deg, output ready);
endinterface

`default_nettype wire

/* src/compass_heading_from_xy.sv */
// an item moves through the input stage, cordic stages, angle and heading registers
// throughput: one item per cycle unless stalled, one cordic iteration per pipeline stage
// each stage holds while the stage after it is full and stalled, bubbles fill in
// reset clears the valid bits of all stages, the data registers keep no reset
// input ready follows output ready combinationally through the stage chain
`default_nettype none

module compass_heading_from_xy import chxy_pkg::*; #(
	parameter int FRAC_BITS    = 7,
	parameter int CORDIC_STEPS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	chxy_xy_if.sink    xy,
	chxy_hdg_if.source hdg
);

	localparam int N    = CORDIC_STEPS;
	localparam int LAST = N + 2;
	localparam int RS   = ANG_FRAC - FRAC_BITS;
	localparam logic [TW-1:0] HALF_RND = TW'(1) << (RS - 1);
	localparam logic [TW-1:0] FULL_Q   = TW'(360) << FRAC_BITS;

	logic [LAST:0]   v_s;
	logic [LAST:0]   v_in;
	logic [LAST+1:0] en;

	logic signed [XW-1:0] cx_s [0:N];
	logic signed [XW-1:0] cy_s [0:N];
	logic signed [ZW-1:0] cz_s [0:N];
	logic [N:0]           nx_s;
	logic [N:0]           ny_s;
	logic [N:0]           zr_s;
	logic [TW-1:0]        ang_s;
	logic [OUT_W-1:0]     hd_s;

	logic signed [IN_W:0] xe;
	logic signed [IN_W:0] ye;
	logic [IN_W:0]        ax;
	logic [IN_W:0]        ay;
	logic [TW-1:0]        a_clamp;
	logic [TW-1:0]        total;
	logic [TW-1:0]        rnd_sum;
	logic [TW-1:0]        q;
	logic [TW-1:0]        q_wrap;

	// stall chain
	assign en[LAST+1] = hdg.ready;
	for (genvar k = 0; k <= LAST; k++) begin : g_en
		assign en[k] = ~v_s[k] | en[k+1];
	end
	assign xy.ready = en[0];
	assign v_in     = {v_s[LAST-1:0], xy.valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int k = 0; k <= LAST; k++) begin
				if (en[k]) begin
					v_s[k] <= v_in[k];
				end
			end
		end
	end

	// absolute values of the input pair
	always_comb begin
		xe = {xy.field_x[IN_W-1], xy.field_x};
		ye = {xy.field_y[IN_W-1], xy.field_y};
		ax = xe[IN_W] ? (IN_W+1)'(-xe) : (IN_W+1)'(xe);
		ay = ye[IN_W] ? (IN_W+1)'(-ye) : (IN_W+1)'(ye);
	end

	// input stage and cordic iterations
	always_ff @(posedge clk) begin
		if (en[0]) begin
			cx_s[0] <= $signed(XW'(ax) << PRESCALE);
			cy_s[0] <= $signed(XW'(ay) << PRESCALE);
			cz_s[0] <= '0;
			nx_s[0] <= xy.field_x[IN_W-1];
			ny_s[0] <= xy.field_y[IN_W-1];
			zr_s[0] <= (xy.field_x == '0) && (xy.field_y == '0);
		end
		for (int i = 0; i < N; i++) begin
			if (en[i+1]) begin
				if (!cy_s[i][XW-1]) begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + $signed(ZW'(ATAN_TAB[i]));
				end else begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - $signed(ZW'(ATAN_TAB[i]));
				end
				nx_s[i+1] <= nx_s[i];
				ny_s[i+1] <= ny_s[i];
				zr_s[i+1] <= zr_s[i];
			end
		end
	end

	// clamp to the first quadrant and map by the input signs
	always_comb begin
		if (zr_s[N] || cz_s[N][ZW-1]) begin
			a_clamp = '0;
		end else if (cz_s[N] > $signed(ZW'(A90))) begin
			a_clamp = A90;
		end else begin
			a_clamp = cz_s[N][TW-1:0];
		end
		case (quad_t'({nx_s[N], ny_s[N]}))
			QUAD_PP: total = a_clamp;
			QUAD_NP: total = A180 - a_clamp;
			QUAD_NN: total = A180 + a_clamp;
			QUAD_PN: total = A360 - a_clamp;
			default: total = a_clamp;
		endcase
	end

	// round half up and wrap a full circle to zero
	always_comb begin
		rnd_sum = ang_s + HALF_RND;
		q       = rnd_sum >> RS;
		q_wrap  = (q >= FULL_Q) ? (q - FULL_Q) : q;
	end

	always_ff @(posedge clk) begin
		if (en[N+1]) begin
			ang_s <= total;
		end
		if (en[LAST]) begin
			hd_s <= q_wrap[OUT_W-1:0];
		end
	end

	assign hdg.valid       = v_s[LAST];
	assign hdg.heading_deg = hd_s;

endmodule

`default_nettype wire

/* src/chxy_checker.sv */
// port checks of the compass heading block and their binding
`default_nettype none

`include "compass_heading_from_xy_macros.svh"

module chxy_checker import chxy_pkg::*; #(
	parameter int FRAC_BITS = 7
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [OUT_W-1:0] heading_deg
);

	localparam int FULL  = 360 << FRAC_BITS;
	localparam bit WRAPS = FULL > 65535;

	`CHXY_ASSERT(a_heading_range, out_valid |-> (WRAPS || heading_deg < OUT_W'(FULL)), "heading at or above a full circle")
	`CHXY_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(heading_deg)), "stalled item changed")
	`CHXY_ASSERT(a_no_backpressure, (!out_valid || out_ready) |-> in_ready, "input stalled while output drains")
	`CHXY_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !out_valid, "output valid during reset")

endmodule

bind compass_heading_from_xy chxy_checker #(.FRAC_BITS(FRAC_BITS)) u_chxy_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (xy.ready),
	.out_valid  (hdg.valid),
	.out_ready  (hdg.ready),
	.heading_deg(hdg.heading_deg)
);

`default_nettype wire
